/* rtl/bpa_pkg.sv */
// Shared types and constants for the buddy page allocator.
// Used by the page RAM, the sequencer, the top level and the checker.
`default_nettype none
package bpa_pkg;
    localparam int PAGE_COUNT = 4096;
    localparam int MAX_ORDER  = 10;
    localparam int IDX_W      = 12;
    localparam int LINK_W     = 13;
    localparam int ORD_W      = 5;
    localparam int LVL_W      = 4;
    localparam int LVL_N      = MAX_ORDER + 1;

    localparam logic [LINK_W-1:0] NIL       = LINK_W'(PAGE_COUNT);
    localparam logic [ORD_W-1:0]  TAGALONG  = 5'd31;
    localparam logic [LVL_W-1:0]  MAX_LVL   = LVL_W'(MAX_ORDER);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_MEM   = 2'd1,
        ST_BAD_ORD  = 2'd2,
        ST_BAD_FREE = 2'd3
    } status_t;

    typedef struct packed {
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
        logic [ORD_W-1:0]  order;
        logic              free;
        logic              used;
    } page_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        page_t            wdata;
    } ram_req_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] granted;
        status_t          status;
    } res_t;

    localparam page_t DEAD_PAGE = '{next: NIL, prev: NIL, order: TAGALONG, free: 1'b0,
                                    used: 1'b0};
endpackage
`default_nettype wire

/* rtl/bpa_page_ram.sv */
// Single-port page RAM holding per-page links, order and flags.
// Depends on bpa_pkg; read data is registered.
`default_nettype none
module bpa_page_ram
    import bpa_pkg::*;
(
    input  wire logic     aclk,
    input  wire ram_req_t req,
    output page_t         rd_data
);
    page_t mem [PAGE_COUNT];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        rd_data <= mem[req.addr];
    end
endmodule
`default_nettype wire

/* rtl/bpa_seq.sv */
// Command sequencer: free list heads, clearing sweep and list walks.
// Depends on bpa_pkg; drives the single port of bpa_page_ram.
`default_nettype none
module bpa_seq
    import bpa_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire logic             cmd,
    input  wire logic [3:0]       req_order,
    input  wire logic [IDX_W-1:0] page_index,
    input  wire logic             out_free,
    output res_t                  res,
    output ram_req_t              ram_req,
    input  wire page_t            rd_data
);
    typedef enum logic [16:0] {
        S_CLEAR  = 17'h00001,
        S_IDLE   = 17'h00002,
        S_SCAN   = 17'h00004,
        S_A_UNL  = 17'h00008,
        S_A_NPRV = 17'h00010,
        S_A_SPLIT= 17'h00020,
        S_F_CHK  = 17'h00040,
        S_F_BUD  = 17'h00080,
        S_F_BCHK = 17'h00100,
        S_F_UNV  = 17'h00200,
        S_F_VW   = 17'h00400,
        S_F_UNN  = 17'h00800,
        S_F_NW   = 17'h01000,
        S_F_PUSH = 17'h02000,
        S_F_HRD  = 17'h04000,
        S_F_HW   = 17'h08000,
        S_DONE   = 17'h10000
    } state_t;

    state_t            state_reg, state_next;
    logic [LVL_W-1:0]  o_reg, o_next;
    logic [LVL_W-1:0]  req_reg, req_next;
    logic [IDX_W-1:0]  p_reg, p_next;
    logic [LINK_W-1:0] tmp_reg, tmp_next;
    logic [LINK_W-1:0] v_reg, v_next;
    logic [LINK_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [LINK_W-1:0] head_reg [LVL_N];
    logic [LINK_W-1:0] head_next [LVL_N];
    logic [IDX_W-1:0]  gr_reg, gr_next;
    status_t           st_reg, st_next;

    logic [IDX_W-1:0]  unit_bit;
    logic [IDX_W-1:0]  buddy;
    logic [LINK_W-1:0] clr_fwd;
    page_t             clr_word;
    page_t             wword;

    assign unit_bit = IDX_W'(1) << ((state_reg == S_A_SPLIT) ? (o_reg - 4'd1) : o_reg);
    assign buddy    = p_reg ^ unit_bit;
    assign clr_fwd  = {1'b0, clr_reg} + LINK_W'(1 << MAX_ORDER);

    always_comb begin
        clr_word = DEAD_PAGE;
        if (clr_reg[MAX_ORDER-1:0] == '0) begin
            clr_word.order = ORD_W'(MAX_ORDER);
            clr_word.free  = 1'b1;
            clr_word.next  = (clr_fwd >= NIL) ? NIL : clr_fwd;
            clr_word.prev  = (clr_reg == '0) ? NIL
                           : ({1'b0, clr_reg} - LINK_W'(1 << MAX_ORDER));
        end
    end

    always_comb begin
        state_next = state_reg;
        o_next     = o_reg;
        req_next   = req_reg;
        p_next     = p_reg;
        tmp_next   = tmp_reg;
        v_next     = v_reg;
        n_next     = n_reg;
        clr_next   = clr_reg;
        gr_next    = gr_reg;
        st_next    = st_reg;
        head_next  = head_reg;
        ram_req    = '{we: 1'b0, addr: p_reg, wdata: DEAD_PAGE};
        wword      = rd_data;
        res        = '{valid: 1'b0, granted: gr_reg, status: st_reg};
        cmd_ready  = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                ram_req = '{we: 1'b1, addr: clr_reg, wdata: clr_word};
                clr_next = clr_reg + 12'd1;
                if (clr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd_ready = 1'b1;
                ram_req.addr = page_index;
                if (cmd_valid) begin
                    req_next = req_order;
                    o_next   = req_order;
                    p_next   = page_index;
                    gr_next  = '0;
                    st_next  = ST_OK;
                    if (cmd == CMD_FREE) begin
                        state_next = S_F_CHK;
                    end else if (req_order > MAX_LVL) begin
                        st_next    = ST_BAD_ORD;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (head_reg[o_reg] != NIL) begin
                    p_next       = head_reg[o_reg][IDX_W-1:0];
                    ram_req.addr = head_reg[o_reg][IDX_W-1:0];
                    state_next   = S_A_UNL;
                end else if (o_reg == MAX_LVL) begin
                    st_next    = ST_NO_MEM;
                    state_next = S_DONE;
                end else begin
                    o_next = o_reg + 4'd1;
                end
            end
            S_A_UNL: begin
                head_next[o_reg] = rd_data.next;
                tmp_next         = rd_data.next;
                ram_req.addr     = rd_data.next[IDX_W-1:0];
                state_next       = (rd_data.next != NIL) ? S_A_NPRV : S_A_SPLIT;
            end
            S_A_NPRV: begin
                wword.prev = NIL;
                ram_req    = '{we: 1'b1, addr: tmp_reg[IDX_W-1:0], wdata: wword};
                state_next = S_A_SPLIT;
            end
            S_A_SPLIT: begin
                if (o_reg > req_reg) begin
                    wword       = DEAD_PAGE;
                    wword.order = ORD_W'(o_reg - 4'd1);
                    wword.free  = 1'b1;
                    ram_req     = '{we: 1'b1, addr: p_reg + unit_bit, wdata: wword};
                    head_next[o_reg - 4'd1] = {1'b0, p_reg + unit_bit};
                    o_next      = o_reg - 4'd1;
                end else begin
                    wword       = DEAD_PAGE;
                    wword.order = ORD_W'(req_reg);
                    wword.used  = 1'b1;
                    ram_req     = '{we: 1'b1, addr: p_reg, wdata: wword};
                    gr_next     = p_reg;
                    state_next  = S_DONE;
                end
            end
            S_F_CHK: begin
                if (!rd_data.used) begin
                    st_next    = ST_BAD_FREE;
                    state_next = S_DONE;
                end else begin
                    o_next     = (rd_data.order > ORD_W'(MAX_ORDER)) ? MAX_LVL
                                                                      : rd_data.order[LVL_W-1:0];
                    state_next = S_F_BUD;
                end
            end
            S_F_BUD: begin
                ram_req.addr = buddy;
                state_next   = (o_reg == MAX_LVL) ? S_F_PUSH : S_F_BCHK;
            end
            S_F_BCHK: begin
                if (!rd_data.free || rd_data.order != {1'b0, o_reg}) begin
                    state_next = S_F_PUSH;
                end else begin
                    n_next     = rd_data.next;
                    v_next     = rd_data.prev;
                    ram_req    = '{we: 1'b1, addr: (buddy > p_reg) ? buddy : p_reg,
                                   wdata: DEAD_PAGE};
                    p_next     = (buddy < p_reg) ? buddy : p_reg;
                    state_next = S_F_UNV;
                end
            end
            S_F_UNV: begin
                ram_req.addr = v_reg[IDX_W-1:0];
                if (v_reg != NIL) begin
                    state_next = S_F_VW;
                end else begin
                    head_next[o_reg] = n_reg;
                    state_next       = S_F_UNN;
                end
            end
            S_F_VW: begin
                wword.next = n_reg;
                ram_req    = '{we: 1'b1, addr: v_reg[IDX_W-1:0], wdata: wword};
                state_next = S_F_UNN;
            end
            S_F_UNN: begin
                ram_req.addr = n_reg[IDX_W-1:0];
                if (n_reg != NIL) begin
                    state_next = S_F_NW;
                end else begin
                    o_next     = o_reg + 4'd1;
                    state_next = S_F_BUD;
                end
            end
            S_F_NW: begin
                wword.prev = v_reg;
                ram_req    = '{we: 1'b1, addr: n_reg[IDX_W-1:0], wdata: wword};
                o_next     = o_reg + 4'd1;
                state_next = S_F_BUD;
            end
            S_F_PUSH: begin
                wword       = DEAD_PAGE;
                wword.next  = head_reg[o_reg];
                wword.order = ORD_W'(o_reg);
                wword.free  = 1'b1;
                ram_req     = '{we: 1'b1, addr: p_reg, wdata: wword};
                head_next[o_reg] = {1'b0, p_reg};
                tmp_next    = head_reg[o_reg];
                state_next  = (head_reg[o_reg] != NIL) ? S_F_HRD : S_DONE;
            end
            S_F_HRD: begin
                ram_req.addr = tmp_reg[IDX_W-1:0];
                state_next   = S_F_HW;
            end
            S_F_HW: begin
                wword.prev = {1'b0, p_reg};
                ram_req    = '{we: 1'b1, addr: tmp_reg[IDX_W-1:0], wdata: wword};
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    res.valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            for (int i = 0; i < LVL_N; i++) begin
                head_reg[i] <= (i == MAX_ORDER) ? '0 : NIL;
            end
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge aclk) begin
        o_reg   <= o_next;
        req_reg <= req_next;
        p_reg   <= p_next;
        tmp_reg <= tmp_next;
        v_reg   <= v_next;
        n_reg   <= n_next;
        gr_reg  <= gr_next;
        st_reg  <= st_next;
    end
endmodule
`default_nettype wire

/* rtl/buddy_page_allocator_core.sv */
// Top level of the buddy page allocator: sequencer, page RAM and result register.
// Depends on bpa_pkg, bpa_seq and bpa_page_ram.
`default_nettype none
// Buddy allocator over 4096 pages with orders 0 to 10. After reset the block
// clears its page RAM, one page per cycle, with s_ready low. Commands then run
// one at a time through a sequencer that shares one single-port page RAM. An
// allocate scans the free lists upward from the requested order, unlinks the
// list head it finds and splits the block down to the requested order. A free
// checks the page, merges it with each free buddy of equal order and pushes the
// merged block onto its free list. A rejected command skips the list work.
// Each list link update on the RAM port is a read followed by a write. A finished
// result waits in an output register while the next command is taken.
module buddy_page_allocator_core
    import bpa_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_cmd,
    input  wire logic [3:0]       s_block_size_order,
    input  wire logic [IDX_W-1:0] s_page_index,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [IDX_W-1:0]      m_granted_index,
    output logic [1:0]            m_status
);
    ram_req_t         ram_req;
    page_t            rd_data;
    res_t             res;
    logic             m_valid_reg;
    logic [IDX_W-1:0] m_granted_reg;
    status_t          m_status_reg;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    bpa_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (s_valid),
        .cmd_ready  (s_ready),
        .cmd        (s_cmd),
        .req_order  (s_block_size_order),
        .page_index (s_page_index),
        .out_free   (out_free),
        .res        (res),
        .ram_req    (ram_req),
        .rd_data    (rd_data)
    );

    bpa_page_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_granted_reg <= res.granted;
            m_status_reg  <= res.status;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_granted_index = m_granted_reg;
    assign m_status        = m_status_reg;
endmodule
`default_nettype wire

/* rtl/bpa_checker.sv */
// Port-level checker for the buddy page allocator, bound to the top level.
// Depends on bpa_pkg.
`default_nettype none
module bpa_checker
    import bpa_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic [IDX_W-1:0] m_granted_index,
    input wire logic [1:0]       m_status
);
    a_busy_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready stayed high after a command transfer");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_granted_index == '0)
        else $error("failed result carries a nonzero index");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted_index) && $stable(m_status))
        else $error("result changed while stalled");

    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("block active right after reset");
endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_granted_index (m_granted_index),
    .m_status        (m_status)
);
`default_nettype wire
